[sv/eipf_pkg.sv]
// ----------------------------------------------------------------------------
// eipf_pkg
// Shared types, register map, frame offsets and codes for the eCPRI IQ packet
// filter.
// ----------------------------------------------------------------------------
package eipf_pkg;

  localparam int unsigned PAYLOAD_MAX = 4096;
  localparam int unsigned COUNT_LIMIT = 8191;
  localparam int unsigned COPY_CAP    = (PAYLOAD_MAX < COUNT_LIMIT) ? PAYLOAD_MAX : COUNT_LIMIT;
  localparam int unsigned PAY_CNT_W   = 13;

  localparam logic [15:0] ETYPE_ECPRI = 16'hAEFE;
  localparam logic [15:0] ETYPE_VLAN  = 16'h8100;
  localparam logic [8:0]  PRB_FULL    = 9'd273;

  localparam logic [15:0] OFS_ETYPE     = 16'd14;
  localparam logic [15:0] OFS_INNER     = 16'd18;
  localparam logic [15:0] OFS_ECPRI_END = 16'd22;
  localparam logic [15:0] OFS_APP_END   = 16'd26;
  localparam logic [15:0] OFS_PAYLOAD   = 16'd32;
  localparam logic [15:0] VLAN_LEN      = 16'd4;
  localparam logic [15:0] OFS_MAX       = 16'hFFFF;

  localparam int unsigned REG_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_PERIOD      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXPECTED_PRB_COUNT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_TARGET        = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_SYMBOL      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SYMBOL         = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_EAXC_TARGET        = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SLOTS_PER_SF       = 3'd6;

  localparam logic [1:0] KIND_META    = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [1:0] STAT_CAPTURED  = 2'd0;
  localparam logic [1:0] STAT_DROPPED   = 2'd1;
  localparam logic [1:0] STAT_MALFORMED = 2'd2;

  localparam int unsigned NUM_SLOTS = 3;

  typedef enum logic [3:0] {
    V_PARSING   = 4'b0001,
    V_CAPTURING = 4'b0010,
    V_DROPPED   = 4'b0100,
    V_MALFORMED = 4'b1000
  } verdict_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  frame_num;
    logic [3:0]  subframe_num;
    logic [5:0]  slot_num;
    logic [5:0]  symbol_num;
    logic [11:0] section_num;
    logic [9:0]  start_prb;
    logic [8:0]  prb_count;
    logic [3:0]  comp_meth;
    logic [3:0]  iq_bits;
    logic [12:0] data_value;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] sample_period;
    logic [8:0]  expected_prb_count;
    logic [7:0]  slot_target;
    logic [6:0]  target_symbol;
    logic [5:0]  min_symbol;
    logic [16:0] eaxc_target;
    logic [4:0]  slots_per_sf;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0]            vld;
    out_item_t [NUM_SLOTS-1:0]       row;
  } bundle_t;

endpackage

[sv/eipf_cfg_regs.sv]
// ----------------------------------------------------------------------------
// eipf_cfg_regs
// APB-style register file holding the filter configuration.
// ----------------------------------------------------------------------------
module eipf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [eipf_pkg::REG_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output eipf_pkg::cfg_t                      cfg
);
  import eipf_pkg::*;

  cfg_t                 cfg_r;
  cfg_t                 cfg_nxt;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign idx    = paddr[REG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SAMPLE_PERIOD:      cfg_nxt.sample_period      = pwdata[15:0];
        REG_EXPECTED_PRB_COUNT: cfg_nxt.expected_prb_count = pwdata[8:0];
        REG_SLOT_TARGET:        cfg_nxt.slot_target        = pwdata[7:0];
        REG_TARGET_SYMBOL:      cfg_nxt.target_symbol      = pwdata[6:0];
        REG_MIN_SYMBOL:         cfg_nxt.min_symbol         = pwdata[5:0];
        REG_EAXC_TARGET:        cfg_nxt.eaxc_target        = pwdata[16:0];
        REG_SLOTS_PER_SF:       cfg_nxt.slots_per_sf       = pwdata[4:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAMPLE_PERIOD:      prdata = {16'd0, cfg_r.sample_period};
      REG_EXPECTED_PRB_COUNT: prdata = {23'd0, cfg_r.expected_prb_count};
      REG_SLOT_TARGET:        prdata = {24'd0, cfg_r.slot_target};
      REG_TARGET_SYMBOL:      prdata = {25'd0, cfg_r.target_symbol};
      REG_MIN_SYMBOL:         prdata = {26'd0, cfg_r.min_symbol};
      REG_EAXC_TARGET:        prdata = {15'd0, cfg_r.eaxc_target};
      REG_SLOTS_PER_SF:       prdata = {27'd0, cfg_r.slots_per_sf};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period      <= 16'd0;
      cfg_r.expected_prb_count <= 9'd0;
      cfg_r.slot_target        <= 8'd19;
      cfg_r.target_symbol      <= 7'd13;
      cfg_r.min_symbol         <= 6'd0;
      cfg_r.eaxc_target        <= 17'h1FFFF;
      cfg_r.slots_per_sf       <= 5'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/eipf_parser.sv]
// ----------------------------------------------------------------------------
// eipf_parser
// Byte-serial header parser and filter; forms the results caused by one byte.
// ----------------------------------------------------------------------------
module eipf_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  eipf_pkg::cfg_t      cfg,
  input  eipf_pkg::in_item_t  item,
  input  logic                take,
  output eipf_pkg::bundle_t   bundle
);
  import eipf_pkg::*;

  logic [15:0]          offset_r, offset_nxt;
  logic                 vlan_r, vlan_nxt, vlan_upd;
  logic [63:0]          latch_r, latch_nxt;
  verdict_t             verdict_r, verdict_nxt, verdict_upd;
  logic [15:0]          sample_r, sample_nxt, sample_inc;
  logic [PAY_CNT_W-1:0] pay_cnt_r, pay_cnt_nxt, pay_cnt_upd;

  logic [15:0] ofs_e_end;
  logic [15:0] ofs_a_end;
  logic [15:0] ofs_pay_cur;
  logic [15:0] ofs_pay;
  logic [9:0]  frame_slot;
  logic [8:0]  prbs;
  logic        meta_hit;
  logic        pay_hit;
  out_item_t   meta_row, pay_row, end_row;

  assign ofs_e_end   = OFS_ECPRI_END + (vlan_r ? VLAN_LEN : 16'd0);
  assign ofs_a_end   = OFS_APP_END + (vlan_r ? VLAN_LEN : 16'd0);
  assign ofs_pay_cur = OFS_PAYLOAD + (vlan_r ? VLAN_LEN : 16'd0);
  assign frame_slot  = 10'({6'd0, latch_r[15:12]} * {5'd0, cfg.slots_per_sf})
                       + {4'd0, latch_r[11:6]};
  assign prbs        = (latch_r[15:8] == 8'd0) ? PRB_FULL : {1'b0, latch_r[15:8]};
  assign sample_inc  = sample_r + 16'd1;

  always_comb begin
    vlan_upd    = vlan_r;
    verdict_upd = verdict_r;
    sample_nxt  = sample_r;
    if (verdict_r == V_PARSING) begin
      if (offset_r == OFS_ETYPE) begin
        if (latch_r[15:0] == ETYPE_VLAN) begin
          vlan_upd = 1'b1;
        end else if (latch_r[15:0] != ETYPE_ECPRI) begin
          verdict_upd = V_MALFORMED;
        end
      end else if (vlan_r && offset_r == OFS_INNER) begin
        if (latch_r[15:0] != ETYPE_ECPRI) begin
          verdict_upd = V_MALFORMED;
        end
      end else if (offset_r == ofs_e_end) begin
        if (latch_r[55:48] != 8'd0) begin
          verdict_upd = V_DROPPED;
        end else if (!cfg.eaxc_target[16] && latch_r[31:16] != cfg.eaxc_target[15:0]) begin
          verdict_upd = V_DROPPED;
        end
      end else if (offset_r == ofs_a_end) begin
        if (!cfg.slot_target[7] && frame_slot != {2'b0, cfg.slot_target}) begin
          verdict_upd = V_DROPPED;
        end else if (!cfg.target_symbol[6]) begin
          if (latch_r[5:0] != cfg.target_symbol[5:0]) begin
            verdict_upd = V_DROPPED;
          end
        end else if (latch_r[5:0] < cfg.min_symbol) begin
          verdict_upd = V_DROPPED;
        end
      end else if (offset_r == ofs_pay_cur) begin
        if (cfg.expected_prb_count != 9'd0 && prbs != cfg.expected_prb_count) begin
          verdict_upd = V_DROPPED;
        end else if (cfg.sample_period != 16'd0) begin
          if (sample_inc < cfg.sample_period) begin
            sample_nxt  = sample_inc;
            verdict_upd = V_DROPPED;
          end else begin
            sample_nxt  = 16'd0;
            verdict_upd = V_CAPTURING;
          end
        end else begin
          verdict_upd = V_CAPTURING;
        end
      end
    end
  end

  assign ofs_pay  = OFS_PAYLOAD + (vlan_upd ? VLAN_LEN : 16'd0);
  assign meta_hit = (verdict_r == V_PARSING) && (verdict_upd == V_CAPTURING)
                    && (offset_r == ofs_pay);
  assign pay_hit  = (verdict_upd == V_CAPTURING) && (offset_r >= ofs_pay)
                    && (pay_cnt_r < PAY_CNT_W'(COPY_CAP));
  assign pay_cnt_upd = pay_hit ? pay_cnt_r + PAY_CNT_W'(1) : pay_cnt_r;

  always_comb begin
    latch_nxt = latch_r;
    if (offset_r < ofs_pay - 16'd1) begin
      latch_nxt = {latch_r[55:0], item.packet_byte};
    end
    offset_nxt  = (offset_r != OFS_MAX) ? offset_r + 16'd1 : offset_r;
    vlan_nxt    = vlan_upd;
    verdict_nxt = verdict_upd;
    pay_cnt_nxt = pay_cnt_upd;
    if (item.last_byte) begin
      offset_nxt  = 16'd0;
      vlan_nxt    = 1'b0;
      verdict_nxt = V_PARSING;
      pay_cnt_nxt = '0;
    end
  end

  always_comb begin
    meta_row              = '0;
    meta_row.kind         = KIND_META;
    meta_row.frame_num    = latch_r[63:56];
    meta_row.subframe_num = latch_r[55:52];
    meta_row.slot_num     = latch_r[51:46];
    meta_row.symbol_num   = latch_r[45:40];
    meta_row.section_num  = latch_r[39:28];
    meta_row.start_prb    = latch_r[25:16];
    meta_row.prb_count    = prbs;
    meta_row.comp_meth    = latch_r[3:0];
    meta_row.iq_bits      = latch_r[7:4];

    pay_row            = '0;
    pay_row.kind       = KIND_PAYLOAD;
    pay_row.data_value = {5'd0, item.packet_byte};

    end_row      = '0;
    end_row.kind = KIND_END;
    case (verdict_upd)
      V_CAPTURING: begin
        end_row.status     = STAT_CAPTURED;
        end_row.data_value = pay_cnt_upd;
      end
      V_DROPPED:   end_row.status = STAT_DROPPED;
      default:     end_row.status = STAT_MALFORMED;
    endcase
  end

  assign bundle.vld = {item.last_byte, pay_hit, meta_hit};
  assign bundle.row = {end_row, pay_row, meta_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= 16'd0;
      vlan_r    <= 1'b0;
      verdict_r <= V_PARSING;
      sample_r  <= 16'd0;
      pay_cnt_r <= '0;
    end else if (take) begin
      offset_r  <= offset_nxt;
      vlan_r    <= vlan_nxt;
      verdict_r <= verdict_nxt;
      sample_r  <= sample_nxt;
      pay_cnt_r <= pay_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      latch_r <= latch_nxt;
    end
  end

endmodule

[sv/eipf_out_stage.sv]
// ----------------------------------------------------------------------------
// eipf_out_stage
// Result register for up to three results of one byte, drained one per cycle as out_ready allows.
// ----------------------------------------------------------------------------
module eipf_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  eipf_pkg::bundle_t   bundle,
  input  logic                load,
  input  logic                out_ready,
  output logic                out_valid,
  output eipf_pkg::out_item_t out_data,
  output logic                free
);
  import eipf_pkg::*;

  logic [NUM_SLOTS-1:0]      vld_r, vld_nxt;
  out_item_t [NUM_SLOTS-1:0] row_r;
  logic [NUM_SLOTS-1:0]      first;
  logic [NUM_SLOTS-1:0]      vld_left;
  logic                      fire;

  assign first     = vld_r & (~vld_r + NUM_SLOTS'(1));
  assign out_valid = |vld_r;
  assign fire      = out_valid && out_ready;
  assign vld_left  = fire ? (vld_r & ~first) : vld_r;
  assign free      = (vld_left == '0);
  assign vld_nxt   = load ? bundle.vld : vld_left;

  always_comb begin
    if (vld_r[0]) begin
      out_data = row_r[0];
    end else if (vld_r[1]) begin
      out_data = row_r[1];
    end else begin
      out_data = row_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_r <= bundle.row;
    end
  end

endmodule

[sv/ecpri_iq_packet_filter_core.sv]
// ----------------------------------------------------------------------------
// ecpri_iq_packet_filter_core
// Byte-serial eCPRI IQ-data frame filter with metadata and payload capture.
// ----------------------------------------------------------------------------
// The block takes frame bytes and shows a byte's first result in the next
// cycle. A byte with one result or none is taken every cycle with out_ready
// high; the first payload byte of a kept packet causes a metadata record and
// a payload byte, and a final byte adds an end status, so such a byte holds
// the input while its results leave the three-entry result register one per
// cycle as out_ready allows. The user must write configuration through the
// APB port only while no frame is in flight; the block does not enforce it.
module ecpri_iq_packet_filter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  eipf_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output eipf_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [eipf_pkg::REG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import eipf_pkg::*;

  cfg_t    cfg;
  bundle_t bundle;
  logic    take;
  logic    free;

  assign in_ready = free;
  assign take     = in_valid && in_ready;

  eipf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eipf_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (in_data),
    .take   (take),
    .bundle (bundle)
  );

  eipf_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .bundle    (bundle),
    .load      (take),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (free)
  );

  a_idle_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_end_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.last_byte) |=> out_valid)
    else $error("final byte produced no end status");

  a_meta_prb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_META) |-> (out_data.prb_count != 9'd0))
    else $error("metadata record carries a zero PRB count");

endmodule
